// File: rtl/tsc_pkg.sv
package tsc_pkg;

	localparam int MAX_WIDTH_DEF  = 80;
	localparam int MAX_HEIGHT_DEF = 24;

	localparam int FUNC_W   = 3;
	localparam int ROW_W    = 5;
	localparam int COL_W    = 7;
	localparam int CHAR_W   = 8;
	localparam int POS_W    = 11;
	localparam int WIDTH_W  = 7;
	localparam int HEIGHT_W = 5;
	// width * row + column never needs more than this
	localparam int DIM_W    = WIDTH_W + HEIGHT_W;

	localparam int RESET_WIDTH  = 80;
	localparam int RESET_HEIGHT = 24;

	localparam logic [CHAR_W-1:0] FILLER = 8'h2E;

	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 1'b1;

	typedef enum logic [FUNC_W-1:0] {
		FN_HOME  = 3'd0,
		FN_FWD   = 3'd1,
		FN_BACK  = 3'd2,
		FN_MOVE  = 3'd3,
		FN_CLEAR = 3'd4,
		FN_GET   = 3'd5,
		FN_SET   = 3'd6
	} func_t;

endpackage

// File: rtl/tsc_cmd_if.sv
interface tsc_cmd_if;
	logic                       valid;
	logic                       ready;
	logic [tsc_pkg::FUNC_W-1:0] func;
	logic [tsc_pkg::ROW_W-1:0]  row;
	logic [tsc_pkg::COL_W-1:0]  column;
	logic [tsc_pkg::CHAR_W-1:0] char_in;

	modport source (output valid, func, row, column, char_in, input ready);
	modport sink (input valid, func, row, column, char_in, output ready);
endinterface

// File: rtl/tsc_rsp_if.sv
interface tsc_rsp_if;
	logic                       valid;
	logic                       ready;
	logic [tsc_pkg::CHAR_W-1:0] char_out;
	logic [tsc_pkg::POS_W-1:0]  cursor_pos;

	modport source (output valid, char_out, cursor_pos, input ready);
	modport sink (input valid, char_out, cursor_pos, output ready);
endinterface

// File: rtl/tsc_cell_ram.sv
module tsc_cell_ram #(
	parameter int DEPTH  = tsc_pkg::MAX_WIDTH_DEF * tsc_pkg::MAX_HEIGHT_DEF,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic                       clk,
	input  logic                       en,
	input  logic                       we,
	input  logic [ADDR_W-1:0]          addr,
	input  logic [tsc_pkg::CHAR_W-1:0] wdata,
	output logic [tsc_pkg::CHAR_W-1:0] rdata
);

	logic [tsc_pkg::CHAR_W-1:0] mem [DEPTH];

	// read data holds until the next read
	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule

// File: rtl/tsc_seq.sv
module tsc_seq #(
	parameter int MAX_WIDTH  = tsc_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = tsc_pkg::MAX_HEIGHT_DEF,
	parameter int CELLS      = MAX_WIDTH * MAX_HEIGHT,
	parameter int CUR_W      = (CELLS > 1) ? $clog2(CELLS) : 1
) (
	input  logic                         clk,
	input  logic                         arst_n,
	tsc_cmd_if.sink                      cmd,
	tsc_rsp_if.source                    rsp,
	input  logic [tsc_pkg::WIDTH_W-1:0]  width,
	input  logic [tsc_pkg::HEIGHT_W-1:0] height,
	output logic                         ram_en,
	output logic                         ram_we,
	output logic [CUR_W-1:0]             ram_addr,
	output logic [tsc_pkg::CHAR_W-1:0]   ram_wdata,
	input  logic [tsc_pkg::CHAR_W-1:0]   ram_rdata
);

	localparam int DIM_W = tsc_pkg::DIM_W;

	typedef enum logic [1:0] {
		ST_INIT,
		ST_IDLE,
		ST_CLR,
		ST_RESP
	} state_t;

	state_t                     state_q;
	logic [CUR_W-1:0]           sweep_q;
	logic [CUR_W-1:0]           cursor_q;
	logic                       use_ram_q;
	logic [tsc_pkg::CHAR_W-1:0] char_q;
	logic                       rsp_valid_q;
	logic [tsc_pkg::CHAR_W-1:0] rsp_char_q;
	logic [tsc_pkg::POS_W-1:0]  rsp_pos_q;

	logic             fire;
	logic [DIM_W-1:0] cells;
	logic [DIM_W-1:0] target;
	logic [CUR_W-1:0] nxt_cur;
	logic             slot_free;
	tsc_pkg::func_t   fn;

	assign fn        = tsc_pkg::func_t'(cmd.func);
	assign cmd.ready = (state_q == ST_IDLE);
	assign fire      = cmd.valid && cmd.ready;
	assign slot_free = !rsp_valid_q || rsp.ready;

	assign cells  = DIM_W'(width) * DIM_W'(height);
	assign target = DIM_W'(width) * DIM_W'(cmd.row) + DIM_W'(cmd.column);

	always_comb begin
		nxt_cur = cursor_q;
		case (fn)
			tsc_pkg::FN_HOME:  nxt_cur = '0;
			tsc_pkg::FN_FWD: begin
				if (DIM_W'(cursor_q) >= cells - DIM_W'(1)) begin
					nxt_cur = '0;
				end else begin
					nxt_cur = cursor_q + CUR_W'(1);
				end
			end
			tsc_pkg::FN_BACK: begin
				if (cursor_q != '0) begin
					nxt_cur = cursor_q - CUR_W'(1);
				end
			end
			tsc_pkg::FN_MOVE: begin
				if (DIM_W'(cmd.row) < DIM_W'(height) && DIM_W'(cmd.column) < DIM_W'(width)) begin
					nxt_cur = target[CUR_W-1:0];
				end else begin
					nxt_cur = '0;
				end
			end
			tsc_pkg::FN_CLEAR: nxt_cur = '0;
			default:           nxt_cur = cursor_q;
		endcase
	end

	// single port: sweep writes, set writes at the old cursor, others but clear read at the new one
	always_comb begin
		ram_en    = 1'b0;
		ram_we    = 1'b0;
		ram_addr  = nxt_cur;
		ram_wdata = tsc_pkg::FILLER;
		case (state_q)
			ST_INIT, ST_CLR: begin
				ram_en   = 1'b1;
				ram_we   = 1'b1;
				ram_addr = sweep_q;
			end
			ST_IDLE: begin
				if (fire && fn == tsc_pkg::FN_SET) begin
					ram_en    = 1'b1;
					ram_we    = 1'b1;
					ram_addr  = cursor_q;
					ram_wdata = cmd.char_in;
				end else if (fire && fn != tsc_pkg::FN_CLEAR) begin
					ram_en = 1'b1;
				end
			end
			default: ram_en = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			sweep_q     <= '0;
			cursor_q    <= '0;
			use_ram_q   <= 1'b0;
			char_q      <= tsc_pkg::FILLER;
			rsp_valid_q <= 1'b0;
			rsp_char_q  <= tsc_pkg::FILLER;
			rsp_pos_q   <= '0;
		end else begin
			// in ST_RESP a free slot is always refilled below
			if (rsp_valid_q && rsp.ready && state_q != ST_RESP) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_INIT: begin
					if (sweep_q == CUR_W'(CELLS - 1)) begin
						sweep_q <= '0;
						state_q <= ST_IDLE;
					end else begin
						sweep_q <= sweep_q + CUR_W'(1);
					end
				end
				ST_IDLE: begin
					if (fire) begin
						cursor_q  <= nxt_cur;
						sweep_q   <= '0;
						use_ram_q <= (fn != tsc_pkg::FN_SET) && (fn != tsc_pkg::FN_CLEAR);
						char_q    <= (fn == tsc_pkg::FN_SET) ? cmd.char_in : tsc_pkg::FILLER;
						state_q   <= (fn == tsc_pkg::FN_CLEAR) ? ST_CLR : ST_RESP;
					end
				end
				ST_CLR: begin
					if (DIM_W'(sweep_q) == cells - DIM_W'(1)) begin
						sweep_q <= '0;
						state_q <= ST_RESP;
					end else begin
						sweep_q <= sweep_q + CUR_W'(1);
					end
				end
				ST_RESP: begin
					if (slot_free) begin
						rsp_valid_q <= 1'b1;
						rsp_char_q  <= use_ram_q ? ram_rdata : char_q;
						rsp_pos_q   <= tsc_pkg::POS_W'(cursor_q);
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.char_out   = rsp_char_q;
	assign rsp.cursor_pos = rsp_pos_q;

endmodule

// File: rtl/text_screen_cursor_buffer.sv
// Character screen buffer with a linear cursor.
// cmd channel: one beat per command (func, row, column, char_in).
// rsp channel: one beat per command with the cell under the cursor and the
// cursor position, both after the command. Results come back in order.
// cfg port: cfg_we writes cfg_data into screen_width (index 0) or
// screen_height (index 1, low HEIGHT_W bits); values are clamped to 1..max. Write only while idle.
// Timing: a non-clear command is taken in ST_IDLE, then in ST_RESP its result
// lands in the output register once that is free; only then is a new command
// taken. Clear writes one cell per cycle over width*height cells. Both paces
// come from the single-port cell RAM (one access per cycle).
// Reset: the cursor goes to 0 and the RAM is swept to '.' one cell a cycle,
// over all MAX_WIDTH*MAX_HEIGHT cells (1920 by default) with cmd.ready low.
// Stall: the output register holds a result while rsp.ready is low; the next
// command is still taken and waits for the register to free up.
module text_screen_cursor_buffer #(
	parameter int MAX_WIDTH  = tsc_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = tsc_pkg::MAX_HEIGHT_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	tsc_cmd_if.sink                       cmd,
	tsc_rsp_if.source                     rsp,
	input  logic                          cfg_we,
	input  logic [tsc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [tsc_pkg::WIDTH_W-1:0]   cfg_data
);

	localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;
	localparam int CUR_W = (CELLS > 1) ? $clog2(CELLS) : 1;
	localparam int WW    = tsc_pkg::WIDTH_W;
	localparam int HW    = tsc_pkg::HEIGHT_W;

	localparam logic [WW-1:0] W_RST =
		WW'((tsc_pkg::RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : tsc_pkg::RESET_WIDTH);
	localparam logic [HW-1:0] H_RST =
		HW'((tsc_pkg::RESET_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : tsc_pkg::RESET_HEIGHT);

	logic [WW-1:0] width_q;
	logic [HW-1:0] height_q;
	logic [WW-1:0] width_clamp;
	logic [HW-1:0] height_clamp;

	logic                       ram_en;
	logic                       ram_we;
	logic [CUR_W-1:0]           ram_addr;
	logic [tsc_pkg::CHAR_W-1:0] ram_wdata;
	logic [tsc_pkg::CHAR_W-1:0] ram_rdata;

	always_comb begin
		if (cfg_data == '0) begin
			width_clamp = WW'(1);
		end else if ((WW + 1)'(cfg_data) > (WW + 1)'(MAX_WIDTH)) begin
			width_clamp = WW'(MAX_WIDTH);
		end else begin
			width_clamp = cfg_data;
		end
		if (cfg_data[HW-1:0] == '0) begin
			height_clamp = HW'(1);
		end else if ((HW + 1)'(cfg_data[HW-1:0]) > (HW + 1)'(MAX_HEIGHT)) begin
			height_clamp = HW'(MAX_HEIGHT);
		end else begin
			height_clamp = cfg_data[HW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= W_RST;
			height_q <= H_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				tsc_pkg::CFG_WIDTH:  width_q  <= width_clamp;
				tsc_pkg::CFG_HEIGHT: height_q <= height_clamp;
				default: ;
			endcase
		end
	end

	tsc_seq #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.CELLS      (CELLS),
		.CUR_W      (CUR_W)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.rsp       (rsp),
		.width     (width_q),
		.height    (height_q),
		.ram_en    (ram_en),
		.ram_we    (ram_we),
		.ram_addr  (ram_addr),
		.ram_wdata (ram_wdata),
		.ram_rdata (ram_rdata)
	);

	tsc_cell_ram #(
		.DEPTH  (CELLS),
		.ADDR_W (CUR_W)
	) u_ram (
		.clk   (clk),
		.en    (ram_en),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

endmodule

// File: tb/tb_text_screen_cursor_buffer.sv
module tb_text_screen_cursor_buffer;

	localparam int FUNC_W      = tsc_pkg::FUNC_W;
	localparam int ROW_W       = tsc_pkg::ROW_W;
	localparam int COL_W       = tsc_pkg::COL_W;
	localparam int CHAR_W      = tsc_pkg::CHAR_W;
	localparam int POS_W       = tsc_pkg::POS_W;
	localparam int WIDTH_W     = tsc_pkg::WIDTH_W;
	localparam int HEIGHT_W    = tsc_pkg::HEIGHT_W;
	localparam int CFG_IDX_W   = tsc_pkg::CFG_IDX_W;
	localparam int SCR_MAX_W   = tsc_pkg::MAX_WIDTH_DEF;
	localparam int SCR_MAX_H   = tsc_pkg::MAX_HEIGHT_DEF;
	localparam int STORE_CELLS = SCR_MAX_W * SCR_MAX_H;
	localparam logic [FUNC_W-1:0] FN_UNUSED = 3'd7;
	// must outlast a clear (width*height cells) and the reset sweep (STORE_CELLS cells)
	localparam int STALL_LIMIT = 8000;
	localparam int DRAIN_CYCLES = 20;
	localparam int PHASES = 10;
	localparam int ITEMS_PER_PHASE = 90;

	typedef struct packed {
		logic [CHAR_W-1:0] glyph;
		logic [POS_W-1:0]  pos;
	} cell_view_t;

	class screen_shadow;
		logic [CHAR_W-1:0] cells [STORE_CELLS];
		int unsigned cursor;
		int unsigned width;
		int unsigned height;
		cell_view_t expected_views[$];
		int errors;

		function new();
			foreach (cells[i])
				cells[i] = tsc_pkg::FILLER;
			cursor = 0;
			width = tsc_pkg::RESET_WIDTH;
			height = tsc_pkg::RESET_HEIGHT;
			errors = 0;
		endfunction

		function int unsigned clamp_dim(int unsigned v, int unsigned top);
			if (v == 0)
				return 1;
			if (v > top)
				return top;
			return v;
		endfunction

		function void apply_config(logic [CFG_IDX_W-1:0] idx, logic [WIDTH_W-1:0] data);
			if (idx == tsc_pkg::CFG_WIDTH)
				width = clamp_dim(data, SCR_MAX_W);
			else
				height = clamp_dim(data[HEIGHT_W-1:0], SCR_MAX_H);
		endfunction

		function int pending();
			return expected_views.size();
		endfunction

		function void note_command(logic [FUNC_W-1:0] f, logic [ROW_W-1:0] r,
				logic [COL_W-1:0] c, logic [CHAR_W-1:0] ch);
			int unsigned area;
			cell_view_t v;
			area = width * height;
			case (f)
				tsc_pkg::FN_HOME: cursor = 0;
				tsc_pkg::FN_FWD: begin
					// also wraps when a shrunk screen left the cursor past the end
					if (cursor >= area - 1)
						cursor = 0;
					else
						cursor = cursor + 1;
				end
				tsc_pkg::FN_BACK: begin
					if (cursor > 0)
						cursor = cursor - 1;
				end
				tsc_pkg::FN_MOVE: begin
					if (r < height && c < width)
						cursor = width * r + c;
					else
						cursor = 0;
				end
				tsc_pkg::FN_CLEAR: begin
					for (int unsigned i = 0; i < area; i++)
						cells[i] = tsc_pkg::FILLER;
					cursor = 0;
				end
				tsc_pkg::FN_SET: cells[cursor] = ch;
				default: ;
			endcase
			v.glyph = cells[cursor];
			v.pos = cursor[POS_W-1:0];
			expected_views.push_back(v);
		endfunction

		task report(string msg);
			$display("mismatch: %s", msg);
			errors++;
		endtask

		task check_view(logic [CHAR_W-1:0] glyph, logic [POS_W-1:0] pos);
			cell_view_t want;
			if (expected_views.size() == 0) begin
				report($sformatf("result beat with nothing expected: char %h pos %0d",
					glyph, pos));
			end else begin
				want = expected_views.pop_front();
				if (glyph !== want.glyph)
					report($sformatf("char_out %h, expected %h (pos %0d)",
						glyph, want.glyph, want.pos));
				if (pos !== want.pos)
					report($sformatf("cursor_pos %0d, expected %0d", pos, want.pos));
			end
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [WIDTH_W-1:0] cfg_data;
	int idle_mode;
	int quiet_cycles = 0;
	screen_shadow sb;

	tsc_cmd_if cmd_bus();
	tsc_rsp_if rsp_bus();

	text_screen_cursor_buffer u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_bus),
		.rsp(rsp_bus),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// idle_mode: 0 none, 1 sender gaps, 2 receiver stalls, 3 both
	function bit sender_idles();
		if (idle_mode == 1)
			return $urandom_range(0, 99) < 48;
		if (idle_mode == 3)
			return $urandom_range(0, 99) < 26;
		return 1'b0;
	endfunction

	function bit receiver_stalls();
		if (idle_mode == 2)
			return $urandom_range(0, 99) < 48;
		if (idle_mode == 3)
			return $urandom_range(0, 99) < 26;
		return 1'b0;
	endfunction

	always @(posedge clk) begin
		if (arst_n && rsp_bus.valid && rsp_bus.ready)
			sb.check_view(rsp_bus.char_out, rsp_bus.cursor_pos);
		rsp_bus.ready <= !receiver_stalls();
	end

	always @(posedge clk) begin
		if ((cmd_bus.valid && cmd_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	task automatic send_cmd(input logic [FUNC_W-1:0] f, input logic [ROW_W-1:0] r,
			input logic [COL_W-1:0] c, input logic [CHAR_W-1:0] ch);
		while (sender_idles()) begin
			cmd_bus.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_bus.valid <= 1'b1;
		cmd_bus.func <= f;
		cmd_bus.row <= r;
		cmd_bus.column <= c;
		cmd_bus.char_in <= ch;
		do
			@(posedge clk);
		while (!cmd_bus.ready);
		sb.note_command(f, r, c, ch);
	endtask

	task automatic send_random();
		int pick;
		logic [FUNC_W-1:0] f;
		logic [ROW_W-1:0] r;
		logic [COL_W-1:0] c;
		pick = $urandom_range(0, 99);
		r = ROW_W'($urandom_range(0, 31));
		c = COL_W'($urandom_range(0, 127));
		if (pick < 6)
			f = tsc_pkg::FN_HOME;
		else if (pick < 24)
			f = tsc_pkg::FN_FWD;
		else if (pick < 38)
			f = tsc_pkg::FN_BACK;
		else if (pick < 58)
			f = tsc_pkg::FN_MOVE;
		else if (pick < 61)
			f = tsc_pkg::FN_CLEAR;
		else if (pick < 71)
			f = tsc_pkg::FN_GET;
		else if (pick < 96)
			f = tsc_pkg::FN_SET;
		else
			f = FN_UNUSED;
		// mostly land on the screen in use
		if (f == tsc_pkg::FN_MOVE && $urandom_range(0, 3) != 0) begin
			r = ROW_W'($urandom_range(0, sb.height - 1));
			c = COL_W'($urandom_range(0, sb.width - 1));
		end
		send_cmd(f, r, c, CHAR_W'($urandom_range(0, 255)));
	endtask

	task automatic drain();
		cmd_bus.valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	task automatic set_screen(input logic [WIDTH_W-1:0] w, input logic [WIDTH_W-1:0] h);
		cfg_we <= 1'b1;
		cfg_index <= tsc_pkg::CFG_WIDTH;
		cfg_data <= w;
		@(posedge clk);
		sb.apply_config(tsc_pkg::CFG_WIDTH, w);
		cfg_index <= tsc_pkg::CFG_HEIGHT;
		cfg_data <= h;
		@(posedge clk);
		sb.apply_config(tsc_pkg::CFG_HEIGHT, h);
		cfg_we <= 1'b0;
	endtask

	initial begin
		logic [WIDTH_W-1:0] cfg_w [PHASES];
		logic [WIDTH_W-1:0] cfg_h [PHASES];
		sb = new();
		idle_mode = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = tsc_pkg::CFG_WIDTH;
		cfg_data = '0;
		cmd_bus.valid = 1'b0;
		cmd_bus.func = tsc_pkg::FN_GET;
		cmd_bus.row = '0;
		cmd_bus.column = '0;
		cmd_bus.char_in = '0;
		cfg_w = '{7'd80, 7'd1, 7'd0, 7'd127, 7'd40, 7'd7, 7'd80, 7'd1, 7'd96, 7'd0};
		cfg_h = '{7'd24, 7'd1, 7'd0, 7'd127, 7'd12, 7'd5, 7'd1, 7'd24, 7'd56, 7'd0};
		cfg_w[PHASES-1] = WIDTH_W'($urandom_range(1, SCR_MAX_W));
		cfg_h[PHASES-1] = WIDTH_W'($urandom_range(1, SCR_MAX_H));

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// reset geometry, store all filler
		send_cmd(tsc_pkg::FN_GET, 5'd0, 7'd0, 8'h00);
		send_cmd(tsc_pkg::FN_BACK, 5'd31, 7'd127, 8'hFF);  // holds at 0
		send_cmd(tsc_pkg::FN_SET, 5'd0, 7'd0, 8'hFF);
		send_cmd(tsc_pkg::FN_FWD, 5'd0, 7'd0, 8'h00);
		send_cmd(tsc_pkg::FN_SET, 5'd31, 7'd127, 8'h00);
		send_cmd(tsc_pkg::FN_MOVE, 5'd23, 7'd79, 8'h00);
		send_cmd(tsc_pkg::FN_SET, 5'd0, 7'd0, 8'hA5);
		send_cmd(tsc_pkg::FN_FWD, 5'd0, 7'd0, 8'h00);      // last cell wraps to 0
		send_cmd(tsc_pkg::FN_MOVE, 5'd24, 7'd0, 8'h00);    // row out of range
		send_cmd(tsc_pkg::FN_MOVE, 5'd0, 7'd80, 8'h00);    // column out of range
		send_cmd(tsc_pkg::FN_MOVE, 5'd31, 7'd127, 8'hFF);
		send_cmd(tsc_pkg::FN_MOVE, 5'd20, 7'd50, 8'h00);
		send_cmd(FN_UNUSED, 5'd31, 7'd127, 8'hFF);
		send_cmd(tsc_pkg::FN_HOME, 5'd0, 7'd0, 8'h00);
		send_cmd(tsc_pkg::FN_CLEAR, 5'd0, 7'd0, 8'h00);
		send_cmd(tsc_pkg::FN_MOVE, 5'd20, 7'd50, 8'h00);
		drain();

		// shrink with the cursor left far past the screen in use
		set_screen(7'd10, 7'd3);
		send_cmd(tsc_pkg::FN_GET, 5'd0, 7'd0, 8'h00);
		send_cmd(tsc_pkg::FN_SET, 5'd0, 7'd0, 8'h77);
		send_cmd(tsc_pkg::FN_BACK, 5'd0, 7'd0, 8'h00);
		send_cmd(tsc_pkg::FN_FWD, 5'd0, 7'd0, 8'h00);
		send_cmd(tsc_pkg::FN_CLEAR, 5'd0, 7'd0, 8'h00);    // leaves the outside cells alone
		drain();
		set_screen(7'd80, 7'd24);
		send_cmd(tsc_pkg::FN_MOVE, 5'd20, 7'd50, 8'h00);
		drain();

		for (int p = 0; p < PHASES; p++) begin
			idle_mode = p % 4;
			set_screen(cfg_w[p], cfg_h[p]);
			for (int n = 0; n < ITEMS_PER_PHASE; n++)
				send_random();
			drain();
		end

		idle_mode = 0;
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule
